// ===== rtl/core/sorted_value_list_macros.svh =====
// Assertion macros for the sorted value list.
// Depends on clk and arst_n in the scope that uses them; no other files.
`ifndef SORTED_VALUE_LIST_MACROS_SVH
`define SORTED_VALUE_LIST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SVL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SVL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

// ===== rtl/core/svl_pkg.sv =====
// Shared types and constants for the sorted value list.
// No dependencies; used by svl_cell and sorted_value_list.
package svl_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned POS_W     = 5;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [POS_W-1:0]        pos_t;

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_FIND   = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	// Per-cell update command: open or close a slot, and where this cell lies.
	typedef struct packed {
		logic ins;
		logic del;
		logic here;
		logic past;
	} cell_cmd_t;

endpackage

// ===== rtl/core/svl_cell.sv =====
// One storage cell of the sorted value list: holds an entry and compares it.
// Depends on svl_pkg.
module svl_cell (
	input  logic              clk,
	input  svl_pkg::cell_cmd_t cmd,
	input  svl_pkg::val_t     new_value,
	input  svl_pkg::val_t     left_value,
	input  svl_pkg::val_t     right_value,
	input  svl_pkg::val_t     cmp_value,
	output svl_pkg::val_t     value,
	output logic              eq,
	output logic              le
);

	svl_pkg::val_t value_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (cmd.here) begin
				value_q <= new_value;
			end else if (cmd.past) begin
				value_q <= left_value;
			end
		end else if (cmd.del && (cmd.here || cmd.past)) begin
			value_q <= right_value;
		end
	end

	assign value = value_q;
	assign eq    = (cmp_value == value_q);
	assign le    = (cmp_value <= value_q);

endmodule

// ===== rtl/core/svl_pick.sv =====
// Priority pick of the lowest set bit of a request vector.
// No dependencies.
module svl_pick #(
	parameter int unsigned N = 16
) (
	input  logic [N-1:0]         req,
	output logic                 hit,
	output logic [$clog2(N)-1:0] idx
);

	localparam int unsigned IW = $clog2(N);

	always_comb begin
		idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (req[i]) begin
				idx = IW'(i);
			end
		end
	end

	assign hit = |req;

endmodule

// ===== rtl/core/sorted_value_list.sv =====
// Sorted value list top level: a row of cells with a compare and pick stage.
// Depends on svl_pkg, svl_cell, svl_pick and sorted_value_list_macros.svh.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------
//  request | start, busy         | op, value, index
//  result  | done (one cycle)    | read_value, position, status, count
//
// For each request the cells compare against value as it is accepted, then
// the pick of the first match and the one-step shift of the row happen in
// the following cycle. done rises in the cycle after that.
// busy is high for the cycle of the pick, so a new request is taken only once the pick is over.
// Reset clears the count; entry contents stay as they are and need no pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "sorted_value_list_macros.svh"

module sorted_value_list #(
	parameter int unsigned DEPTH = svl_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [31:0] value,
	input  logic [3:0]         index,
	output logic               done,
	output logic signed [31:0] read_value,
	output logic [4:0]         position,
	output logic [1:0]         status,
	output logic [4:0]         count
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = ((CW > 4) ? CW : 4) + 1;

	logic                accept;
	logic                vld_s1;
	svl_pkg::op_t        op_s1;
	svl_pkg::val_t       value_s1;
	logic [3:0]          index_s1;
	logic [DEPTH-1:0]    eq_s1;
	logic [DEPTH-1:0]    ge_s1;
	logic                lt0_s1;
	logic [CW-1:0]       cnt_q;

	svl_pkg::val_t       cell_val [DEPTH];
	logic [DEPTH-1:0]    cell_eq;
	logic [DEPTH-1:0]    cell_le;
	logic [DEPTH-1:0]    live;
	svl_pkg::cell_cmd_t  cmd [DEPTH];

	logic                eq_hit;
	logic [IW-1:0]       eq_pos;
	logic                ge_hit;
	logic [IW-1:0]       ge_pos;
	logic                full;
	logic                do_ins;
	logic                do_del;
	logic [CW-1:0]       ins_pos;
	logic [CW-1:0]       tgt;
	logic [XW-1:0]       idx_x;
	logic                in_range;

	svl_pkg::val_t       rd_d;
	logic [CW-1:0]       pos_d;
	svl_pkg::status_t    st_d;

	logic                done_q;
	svl_pkg::val_t       read_value_q;
	svl_pkg::pos_t       position_q;
	svl_pkg::status_t    status_q;

	assign accept = start && !busy;
	assign busy   = vld_s1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		svl_pkg::val_t left_v;
		svl_pkg::val_t right_v;

		if (i == 0) begin : g_head
			assign left_v = value_s1;
		end else begin : g_body
			assign left_v = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_v = cell_val[i];
		end else begin : g_inner
			assign right_v = cell_val[i+1];
		end

		assign live[i]     = (CW'(i) < cnt_q);
		assign cmd[i].ins  = do_ins;
		assign cmd[i].del  = do_del;
		assign cmd[i].here = (CW'(i) == tgt);
		assign cmd[i].past = (CW'(i) > tgt);

		svl_cell u_cell (
			.clk         (clk),
			.cmd         (cmd[i]),
			.new_value   (value_s1),
			.left_value  (left_v),
			.right_value (right_v),
			.cmp_value   (value),
			.value       (cell_val[i]),
			.eq          (cell_eq[i]),
			.le          (cell_le[i])
		);
	end

	// Latch the request and the compare vectors of the whole row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= svl_pkg::op_t'(op);
			value_s1 <= value;
			index_s1 <= index;
			eq_s1    <= cell_eq & live;
			ge_s1    <= cell_le & live & {{(DEPTH-1){1'b1}}, 1'b0};
			lt0_s1   <= (cnt_q == '0) || (cell_le[0] && !cell_eq[0]);
		end
	end

	svl_pick #(.N(DEPTH)) u_pick_eq (
		.req (eq_s1),
		.hit (eq_hit),
		.idx (eq_pos)
	);

	svl_pick #(.N(DEPTH)) u_pick_ge (
		.req (ge_s1),
		.hit (ge_hit),
		.idx (ge_pos)
	);

	assign full     = (cnt_q == CW'(DEPTH));
	assign ins_pos  = lt0_s1 ? '0 : (ge_hit ? CW'(ge_pos) : cnt_q);
	assign idx_x    = XW'(index_s1);
	assign in_range = (idx_x < XW'(cnt_q)) && (idx_x < XW'(DEPTH));

	always_comb begin
		do_ins = 1'b0;
		do_del = 1'b0;
		tgt    = CW'(eq_pos);
		rd_d   = '0;
		pos_d  = '0;
		st_d   = svl_pkg::ST_OK;
		case (op_s1)
			svl_pkg::OP_APPEND: begin
				tgt = cnt_q;
				if (full) begin
					st_d = svl_pkg::ST_FULL;
				end else begin
					do_ins = vld_s1;
					pos_d  = cnt_q;
				end
			end
			svl_pkg::OP_INSERT: begin
				tgt = ins_pos;
				if (full) begin
					st_d = svl_pkg::ST_FULL;
				end else begin
					do_ins = vld_s1;
					pos_d  = ins_pos;
				end
			end
			svl_pkg::OP_DELETE: begin
				if (eq_hit) begin
					do_del = vld_s1;
					pos_d  = CW'(eq_pos);
				end else begin
					st_d = svl_pkg::ST_NOT_FOUND;
				end
			end
			svl_pkg::OP_FIND: begin
				if (eq_hit) begin
					pos_d = CW'(eq_pos);
				end else begin
					st_d = svl_pkg::ST_NOT_FOUND;
				end
			end
			svl_pkg::OP_READ: begin
				if (in_range) begin
					rd_d = cell_val[idx_x[IW-1:0]];
				end else begin
					st_d = svl_pkg::ST_RANGE;
				end
			end
			default: begin
				st_d = svl_pkg::ST_OK;
			end
		endcase
	end

	// Step the count up or down and register the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
			if (do_ins) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_del) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			read_value_q <= rd_d;
			position_q   <= svl_pkg::pos_t'(pos_d);
			status_q     <= st_d;
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;
	assign position   = position_q;
	assign status     = status_q;
	assign count      = svl_pkg::pos_t'(cnt_q);

	`SVL_ASSERT_NEXT(a_result_follows, accept, ##1 done_q, "request without result")
	`SVL_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CW'(DEPTH), "count beyond depth")
	`SVL_ASSERT_NOW(a_count_quiet, !done_q, $stable(cnt_q), "count moved outside a result")
	`SVL_ASSERT_NOW(a_full_flag, done_q && (status_q == svl_pkg::ST_FULL), cnt_q == CW'(DEPTH), "full flagged on a list with room")

endmodule
